// ===== rtl/core/dh_forward_kinematics_6link_core_macros.svh =====
// Assertion macros shared by the forward kinematics core.
`ifndef DH_FORWARD_KINEMATICS_6LINK_CORE_MACROS_SVH
`define DH_FORWARD_KINEMATICS_6LINK_CORE_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define DHFK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define DHFK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dhfk_pkg.sv =====
// Types, constants and helpers for the forward kinematics core.
`timescale 1ns / 1ps
`default_nettype none
package dhfk_pkg;

  localparam int ANG_W    = 16;
  localparam int LEN_W    = 24;
  localparam int ROT_W    = 33;             // Q30 trig and rotation values, with headroom
  localparam int POS_W    = 30;             // Q16 positions, with headroom
  localparam int Z_W      = 32;             // Q28 residual angle
  localparam int OROT_W   = 18;
  localparam int PRR_W    = 2 * ROT_W;
  localparam int PRD_W    = ROT_W + LEN_W;
  localparam int PRP_W    = ROT_W + POS_W;
  localparam int SUM_W    = PRR_W + 2;
  localparam int N_LANES  = 7;
  localparam int N_STEPS  = 28;
  localparam int N_LINKS  = 6;
  localparam int CFG_IDX_W = 3;

  localparam longint ONE_Q30      = 64'sd1073741824;
  localparam longint HALF_Q30     = 64'sd536870912;
  localparam longint GAIN_Q30     = 64'sd652032874;
  localparam longint PI_Q28       = 64'sd843314857;
  localparam longint HALF_PI_Q28  = 64'sd421657428;
  localparam longint ROT_LIMIT    = 64'sd65536;
  localparam longint POS_MAX      = 64'sd8388607;
  localparam longint POS_MIN      = -64'sd8388608;

  // lane order through the sine/cosine chain
  localparam int LN_SHOULDER = 0;
  localparam int LN_ELBOW    = 1;
  localparam int LN_ROLL     = 2;
  localparam int LN_WRIST    = 3;
  localparam int LN_GRASP    = 4;
  localparam int LN_TW12     = 5;
  localparam int LN_TW23     = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TWIST12  = 3'd0,
    CFG_TWIST23  = 3'd1,
    CFG_LINK3LEN = 3'd2,
    CFG_WRISTLEN = 3'd3,
    CFG_TOOLOFF  = 3'd4
  } cfg_idx_e;

  typedef logic signed [ROT_W-1:0] trig_t;
  typedef logic signed [Z_W-1:0]   zang_t;
  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [LEN_W-1:0] len_t;

  typedef struct {
    trig_t x [N_LANES];
    trig_t y [N_LANES];
    zang_t z [N_LANES];
    logic  flip [N_LANES];
    logic  arm;
    len_t  ins;
  } cordic_t;

  typedef struct {
    trig_t ct;
    trig_t st;
    trig_t ca;
    trig_t sa;
    len_t  a;
    len_t  d;
  } link_t;

  typedef struct {
    trig_t r [3][3];
    pos_t  p [3];
  } pose_t;

  typedef struct {
    pose_t pose;
    link_t links [N_LINKS];
  } chain_t;

  // arctangent of 2^-i in Q28
  function automatic zang_t atan_q28(int unsigned i);
    zang_t t;
    unique case (i)
      0: t = Z_W'(210828714);
      1: t = Z_W'(124459457);
      2: t = Z_W'(65760959);
      3: t = Z_W'(33381290);
      4: t = Z_W'(16755422);
      5: t = Z_W'(8385879);
      6: t = Z_W'(4193963);
      7: t = Z_W'(2097109);
      8: t = Z_W'(1048571);
      9: t = Z_W'(524287);
      default: t = Z_W'(64'sd1 <<< (28 - i));
    endcase
    return t;
  endfunction

  // shift a Q60 value back to Q30, rounding half up
  function automatic logic signed [SUM_W-1:0] rnd30(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    t = (v + SUM_W'(HALF_Q30)) >>> 30;
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dh_forward_kinematics_6link_core.sv =====
// Throughput: one word per cycle unless out_ready_i holds a result back, set by the
// 28-cell CORDIC chain and 6 link cells, each stage register passing on in every
// cycle that its successor moves.
// Bubbles collapse, so new words are taken while a finished result waits.
// Reset clears all stage valid bits and sets every configuration register to zero.
`timescale 1ns / 1ps
`default_nettype none
`include "dh_forward_kinematics_6link_core_macros.svh"
module dh_forward_kinematics_6link_core import dhfk_pkg::*; (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [LEN_W-1:0]            cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        arm_select_i,
  input  wire logic signed [ANG_W-1:0]     shoulder_angle_i,
  input  wire logic signed [ANG_W-1:0]     elbow_angle_i,
  input  wire logic signed [LEN_W-1:0]     insertion_depth_i,
  input  wire logic signed [ANG_W-1:0]     roll_angle_i,
  input  wire logic signed [ANG_W-1:0]     wrist_angle_i,
  input  wire logic signed [ANG_W-1:0]     grasp_angle_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [OROT_W-1:0]         rot_xx_o,
  output logic signed [OROT_W-1:0]         rot_xy_o,
  output logic signed [OROT_W-1:0]         rot_xz_o,
  output logic signed [OROT_W-1:0]         rot_yx_o,
  output logic signed [OROT_W-1:0]         rot_yy_o,
  output logic signed [OROT_W-1:0]         rot_yz_o,
  output logic signed [OROT_W-1:0]         rot_zx_o,
  output logic signed [OROT_W-1:0]         rot_zy_o,
  output logic signed [OROT_W-1:0]         rot_zz_o,
  output logic signed [LEN_W-1:0]          pos_x_o,
  output logic signed [LEN_W-1:0]          pos_y_o,
  output logic signed [LEN_W-1:0]          pos_z_o
);

  localparam trig_t ONE  = ROT_W'(ONE_Q30);
  localparam zang_t HPI  = Z_W'(HALF_PI_Q28);
  localparam zang_t PI   = Z_W'(PI_Q28);

  // configuration registers
  logic signed [ANG_W-1:0] tw12_q, tw23_q;
  len_t l3len_q, wlen_q, tool_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw12_q  <= '0;
      tw23_q  <= '0;
      l3len_q <= '0;
      wlen_q  <= '0;
      tool_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TWIST12:  tw12_q  <= cfg_data_i[ANG_W-1:0];
        CFG_TWIST23:  tw23_q  <= cfg_data_i[ANG_W-1:0];
        CFG_LINK3LEN: l3len_q <= cfg_data_i;
        CFG_WRISTLEN: wlen_q  <= cfg_data_i;
        CFG_TOOLOFF:  tool_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front stage: widen angles to Q28 and fold into [-pi/2, pi/2]
  logic signed [ANG_W-1:0] ang [N_LANES];
  cordic_t pre_d, pre_q;
  logic    pre_v_q, pre_adv;
  logic    cc_valid [N_STEPS+1];
  logic    cc_ready [N_STEPS+1];
  cordic_t cc_data  [N_STEPS+1];

  assign ang[LN_SHOULDER] = shoulder_angle_i;
  assign ang[LN_ELBOW]    = elbow_angle_i;
  assign ang[LN_ROLL]     = roll_angle_i;
  assign ang[LN_WRIST]    = wrist_angle_i;
  assign ang[LN_GRASP]    = grasp_angle_i;
  assign ang[LN_TW12]     = tw12_q;
  assign ang[LN_TW23]     = tw23_q;

  always_comb begin
    zang_t z;
    pre_d.arm = arm_select_i;
    pre_d.ins = insertion_depth_i;
    for (int l = 0; l < N_LANES; l++) begin
      z = $signed({ang[l][ANG_W-1], ang[l], 15'b0});
      pre_d.x[l] = ROT_W'(GAIN_Q30);
      pre_d.y[l] = '0;
      if (z > HPI) begin
        pre_d.z[l]    = z - PI;
        pre_d.flip[l] = 1'b1;
      end else if (z < -HPI) begin
        pre_d.z[l]    = z + PI;
        pre_d.flip[l] = 1'b1;
      end else begin
        pre_d.z[l]    = z;
        pre_d.flip[l] = 1'b0;
      end
    end
  end

  assign pre_adv    = !pre_v_q || cc_ready[0];
  assign in_ready_o = pre_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q <= 1'b0;
    end else if (pre_adv) begin
      pre_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pre_adv && in_valid_i) begin
      pre_q <= pre_d;
    end
  end

  assign cc_valid[0] = pre_v_q;
  assign cc_data[0]  = pre_q;

  // sine/cosine chain
  for (genvar g = 0; g < N_STEPS; g++) begin : g_cordic
    dhfk_cordic_cell #(.STEP(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cc_valid[g]),
      .ready_o (cc_ready[g]),
      .data_i  (cc_data[g]),
      .valid_o (cc_valid[g+1]),
      .ready_i (cc_ready[g+1]),
      .data_o  (cc_data[g+1])
    );
  end

  // link table stage: undo the fold, load the link queue, start from identity
  chain_t post_d, post_q;
  logic   post_v_q, post_adv;
  logic   lk_valid [N_LINKS+1];
  logic   lk_ready [N_LINKS+1];
  chain_t lk_data  [N_LINKS+1];
  trig_t  c [N_LANES];
  trig_t  s [N_LANES];
  logic   right;

  assign right = cc_data[N_STEPS].arm;

  always_comb begin
    for (int l = 0; l < N_LANES; l++) begin
      c[l] = cc_data[N_STEPS].flip[l] ? -cc_data[N_STEPS].x[l] : cc_data[N_STEPS].x[l];
      s[l] = cc_data[N_STEPS].flip[l] ? -cc_data[N_STEPS].y[l] : cc_data[N_STEPS].y[l];
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        post_d.pose.r[i][j] = (i == j) ? ONE : '0;
      end
      post_d.pose.p[i] = '0;
    end
    post_d.links[0] = '{ct: c[LN_SHOULDER], st: s[LN_SHOULDER], ca: right ? -ONE : ONE,
                        sa: '0, a: '0, d: '0};
    post_d.links[1] = '{ct: c[LN_ELBOW], st: s[LN_ELBOW], ca: c[LN_TW12], sa: s[LN_TW12],
                        a: '0, d: '0};
    post_d.links[2] = '{ct: '0, st: right ? -ONE : ONE,
                        ca: right ? c[LN_TW23] : -c[LN_TW23], sa: s[LN_TW23],
                        a: '0, d: cc_data[N_STEPS].ins};
    post_d.links[3] = '{ct: c[LN_ROLL], st: s[LN_ROLL], ca: ONE, sa: '0,
                        a: l3len_q, d: tool_q};
    post_d.links[4] = '{ct: c[LN_WRIST], st: s[LN_WRIST], ca: '0, sa: ONE, a: '0, d: '0};
    post_d.links[5] = '{ct: c[LN_GRASP], st: s[LN_GRASP], ca: '0, sa: ONE,
                        a: wlen_q, d: '0};
  end

  assign post_adv          = !post_v_q || lk_ready[0];
  assign cc_ready[N_STEPS] = post_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_v_q <= 1'b0;
    end else if (post_adv) begin
      post_v_q <= cc_valid[N_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (post_adv && cc_valid[N_STEPS]) begin
      post_q <= post_d;
    end
  end

  assign lk_valid[0] = post_v_q;
  assign lk_data[0]  = post_q;

  // link chain
  for (genvar g = 0; g < N_LINKS; g++) begin : g_link
    dhfk_link_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (lk_valid[g]),
      .ready_o (lk_ready[g]),
      .data_i  (lk_data[g]),
      .valid_o (lk_valid[g+1]),
      .ready_i (lk_ready[g+1]),
      .data_o  (lk_data[g+1])
    );
  end

  // output register: round rotation to Q16 and clamp, saturate positions
  logic signed [OROT_W-1:0] rot_d [3][3];
  logic signed [OROT_W-1:0] rot_q [3][3];
  len_t pos_d [3];
  len_t pos_q [3];
  logic out_v_q, out_adv;

  always_comb begin
    logic signed [ROT_W:0] rv;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rv = ((ROT_W + 1)'(lk_data[N_LINKS].pose.r[i][j]) + (ROT_W + 1)'(8192)) >>> 14;
        if (rv > (ROT_W + 1)'(ROT_LIMIT)) begin
          rot_d[i][j] = OROT_W'(ROT_LIMIT);
        end else if (rv < -(ROT_W + 1)'(ROT_LIMIT)) begin
          rot_d[i][j] = -OROT_W'(ROT_LIMIT);
        end else begin
          rot_d[i][j] = rv[OROT_W-1:0];
        end
      end
      if (lk_data[N_LINKS].pose.p[i] > POS_W'(POS_MAX)) begin
        pos_d[i] = LEN_W'(POS_MAX);
      end else if (lk_data[N_LINKS].pose.p[i] < POS_W'(POS_MIN)) begin
        pos_d[i] = LEN_W'(POS_MIN);
      end else begin
        pos_d[i] = lk_data[N_LINKS].pose.p[i][LEN_W-1:0];
      end
    end
  end

  assign out_adv           = !out_v_q || out_ready_i;
  assign lk_ready[N_LINKS] = out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= lk_valid[N_LINKS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && lk_valid[N_LINKS]) begin
      rot_q <= rot_d;
      pos_q <= pos_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign rot_xx_o = rot_q[0][0];
  assign rot_xy_o = rot_q[0][1];
  assign rot_xz_o = rot_q[0][2];
  assign rot_yx_o = rot_q[1][0];
  assign rot_yy_o = rot_q[1][1];
  assign rot_yz_o = rot_q[1][2];
  assign rot_zx_o = rot_q[2][0];
  assign rot_zy_o = rot_q[2][1];
  assign rot_zz_o = rot_q[2][2];
  assign pos_x_o  = pos_q[0];
  assign pos_y_o  = pos_q[1];
  assign pos_z_o  = pos_q[2];

  // a stall at the input can only come from a result word waiting at the output
  `DHFK_ASSERT_IMP(a_stall_source, !in_ready_o, out_valid_o, "input stall without waiting result")
  // an accepted word lands in the front stage
  `DHFK_ASSERT_NXT(a_accept_fill, in_valid_i && in_ready_o, pre_v_q, "accepted word lost")
  // the rotation term rot_xx_o stays inside the clamp window
  `DHFK_ASSERT_IMP(a_rot_clamp, out_valid_o, (rot_xx_o <= 18'sd65536) && (rot_xx_o >= -18'sd65536), "rotation out of range")

endmodule
`default_nettype wire

// ===== rtl/core/dhfk_cordic_cell.sv =====
// One rotation-mode CORDIC iteration over all angle lanes.
`timescale 1ns / 1ps
`default_nettype none
module dhfk_cordic_cell import dhfk_pkg::*; #(
  parameter int STEP = 0
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  output logic         ready_o,
  input  wire cordic_t data_i,
  output logic         valid_o,
  input  wire logic    ready_i,
  output cordic_t      data_o
);

  localparam zang_t ATAN = atan_q28(STEP);

  logic    v_q;
  logic    adv;
  cordic_t d_d, d_q;

  assign adv     = !v_q || ready_i;
  assign ready_o = adv;
  assign valid_o = v_q;
  assign data_o  = d_q;

  // rotate every lane toward zero residual angle
  always_comb begin
    d_d = data_i;
    for (int l = 0; l < N_LANES; l++) begin
      if (data_i.z[l] >= 0) begin
        d_d.x[l] = data_i.x[l] - (data_i.y[l] >>> STEP);
        d_d.y[l] = data_i.y[l] + (data_i.x[l] >>> STEP);
        d_d.z[l] = data_i.z[l] - ATAN;
      end else begin
        d_d.x[l] = data_i.x[l] + (data_i.y[l] >>> STEP);
        d_d.y[l] = data_i.y[l] - (data_i.x[l] >>> STEP);
        d_d.z[l] = data_i.z[l] + ATAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      d_q <= d_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/dhfk_link_cell.sv =====
// One link of the chain: build the link transform and fold it into the pose.
`timescale 1ns / 1ps
`default_nettype none
module dhfk_link_cell import dhfk_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  output logic        ready_o,
  input  wire chain_t data_i,
  output logic        valid_o,
  input  wire logic   ready_i,
  output chain_t      data_o
);

  logic [3:0] v_q;
  logic [3:0] adv;

  // stage payloads
  chain_t s1_q, s2_q, s3_q, s4_d, s4_q;
  logic signed [PRR_W-1:0] m_d [4];
  logic signed [PRR_W-1:0] m_q [4];
  logic signed [PRD_W-1:0] md_d [2];
  logic signed [PRD_W-1:0] md_q [2];
  pose_t l_d, l_q;
  chain_t s2_d;
  logic signed [PRR_W-1:0] prr_d [3][3][3];
  logic signed [PRR_W-1:0] prr_q [3][3][3];
  logic signed [PRP_W-1:0] prp_d [3][3];
  logic signed [PRP_W-1:0] prp_q [3][3];
  trig_t nsa;

  // advance a stage when it is empty or its successor moves
  assign adv[3]  = !v_q[3] || ready_i;
  assign adv[2]  = !v_q[2] || adv[3];
  assign adv[1]  = !v_q[1] || adv[2];
  assign adv[0]  = !v_q[0] || adv[1];
  assign ready_o = adv[0];
  assign valid_o = v_q[3];
  assign data_o  = s4_q;

  // stage 1: trig products of the link, and the trig-scaled offset d
  assign nsa = -data_i.links[0].sa;
  always_comb begin
    m_d[0]  = data_i.links[0].st * data_i.links[0].ca;
    m_d[1]  = data_i.links[0].ct * data_i.links[0].ca;
    m_d[2]  = data_i.links[0].st * data_i.links[0].sa;
    m_d[3]  = data_i.links[0].ct * data_i.links[0].sa;
    md_d[0] = nsa * data_i.links[0].d;
    md_d[1] = data_i.links[0].ca * data_i.links[0].d;
  end

  // stage 2: link transform, shift the link queue
  always_comb begin
    s2_d = s1_q;
    for (int k = 0; k < N_LINKS - 1; k++) begin
      s2_d.links[k] = s1_q.links[k + 1];
    end
    l_d.r[0][0] = s1_q.links[0].ct;
    l_d.r[0][1] = -s1_q.links[0].st;
    l_d.r[0][2] = '0;
    l_d.r[1][0] = ROT_W'(rnd30(SUM_W'(m_q[0])));
    l_d.r[1][1] = ROT_W'(rnd30(SUM_W'(m_q[1])));
    l_d.r[1][2] = -s1_q.links[0].sa;
    l_d.r[2][0] = ROT_W'(rnd30(SUM_W'(m_q[2])));
    l_d.r[2][1] = ROT_W'(rnd30(SUM_W'(m_q[3])));
    l_d.r[2][2] = s1_q.links[0].ca;
    l_d.p[0]    = POS_W'(s1_q.links[0].a);
    l_d.p[1]    = POS_W'(rnd30(SUM_W'(md_q[0])));
    l_d.p[2]    = POS_W'(rnd30(SUM_W'(md_q[1])));
  end

  // stage 3: all partial products of the pose update
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          prr_d[i][j][k] = s2_q.pose.r[i][k] * l_q.r[k][j];
        end
        prp_d[i][k] = s2_q.pose.r[i][k] * l_q.p[k];
      end
    end
  end

  // stage 4: round each three-term sum once, add the old position
  always_comb begin
    s4_d = s3_q;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s4_d.pose.r[i][j] = ROT_W'(rnd30(SUM_W'(prr_q[i][j][0]) + SUM_W'(prr_q[i][j][1])
                                         + SUM_W'(prr_q[i][j][2])));
      end
      s4_d.pose.p[i] = POS_W'(rnd30(SUM_W'(prp_q[i][0]) + SUM_W'(prp_q[i][1])
                                    + SUM_W'(prp_q[i][2]))) + s3_q.pose.p[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= valid_i;
      if (adv[1]) v_q[1] <= v_q[0];
      if (adv[2]) v_q[2] <= v_q[1];
      if (adv[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && valid_i) begin
      s1_q <= data_i;
      m_q  <= m_d;
      md_q <= md_d;
    end
    if (adv[1] && v_q[0]) begin
      s2_q <= s2_d;
      l_q  <= l_d;
    end
    if (adv[2] && v_q[1]) begin
      s3_q  <= s2_q;
      prr_q <= prr_d;
      prp_q <= prp_d;
    end
    if (adv[3] && v_q[2]) begin
      s4_q <= s4_d;
    end
  end

endmodule
`default_nettype wire
